### rtl/atok_pkg.sv
// shared types and constants of the alphanumeric term tokenizer
package atok_pkg;

  localparam int MaxTermLen = 32;
  localparam int BufDepth   = 32;
  localparam int LimitLen   = (MaxTermLen < BufDepth) ? MaxTermLen : BufDepth;
  localparam int BufAw      = $clog2(BufDepth);
  localparam int MemAw      = BufAw + 1;
  localparam int CntW       = $clog2(BufDepth + 1);
  localparam int CharW      = 7;
  localparam int DescDepth  = 2;
  localparam int DescAw     = $clog2(DescDepth);
  localparam int DescCntW   = $clog2(DescDepth + 1);
  localparam int OutDepth   = 2;
  localparam int OutAw      = $clog2(OutDepth);
  localparam int OutCntW    = $clog2(OutDepth + 1);

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5a;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7a;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] CaseOffs = 8'h20;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       flush;
  } in_item_t;

  typedef struct packed {
    logic [6:0] term_char;
    logic [4:0] char_position;
    logic [5:0] term_length;
    logic       last_char;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic [MemAw-1:0] addr;
    logic [CharW-1:0] data;
  } buf_wr_t;

  typedef struct packed {
    logic            valid;
    logic [CntW-1:0] len;
  } desc_push_t;

  typedef struct packed {
    logic            valid;
    logic            full;
    logic [CntW-1:0] len;
  } desc_stat_t;

endpackage

### rtl/atok_front.sv
// front end: byte classification, term gathering and term end detection
module atok_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  atok_pkg::in_item_t  in_data_i,
  input  atok_pkg::desc_stat_t desc_stat_i,
  output atok_pkg::buf_wr_t   buf_wr_o,
  output atok_pkg::desc_push_t desc_push_o
);

  logic [atok_pkg::CntW-1:0] count_q, count_d, cnt_upd;
  logic                      too_long_q, too_long_d, tl_upd;
  logic                      has_letter_q, has_letter_d, hl_upd;
  logic                      bank_q, bank_d;
  logic [7:0]                b;
  logic                      upper, lower, digit, alnum, accept, term_end, emit;

  always_comb begin
    b        = in_data_i.byte_value;
    upper    = (b >= atok_pkg::ChUpperA) && (b <= atok_pkg::ChUpperZ);
    lower    = (b >= atok_pkg::ChLowerA) && (b <= atok_pkg::ChLowerZ);
    digit    = (b >= atok_pkg::ChDigit0) && (b <= atok_pkg::ChDigit9);
    alnum    = upper || lower || digit;
    accept   = push && !desc_stat_i.full;
    cnt_upd  = count_q;
    tl_upd   = too_long_q;
    hl_upd   = has_letter_q;
    buf_wr_o = '0;
    if (alnum) begin
      hl_upd = has_letter_q || upper || lower;
      if (count_q < atok_pkg::CntW'(atok_pkg::LimitLen)) begin
        buf_wr_o.en   = accept;
        buf_wr_o.addr = {bank_q, count_q[atok_pkg::BufAw-1:0]};
        buf_wr_o.data = upper ? atok_pkg::CharW'(b + atok_pkg::CaseOffs)
                              : b[atok_pkg::CharW-1:0];
        cnt_upd       = count_q + atok_pkg::CntW'(1);
      end else begin
        tl_upd = 1'b1;
      end
    end
    term_end          = !alnum || in_data_i.flush;
    emit              = term_end && (cnt_upd != '0) && !tl_upd && hl_upd;
    desc_push_o.valid = accept && emit;
    desc_push_o.len   = cnt_upd;

    count_d      = count_q;
    too_long_d   = too_long_q;
    has_letter_d = has_letter_q;
    bank_d       = bank_q;
    if (accept) begin
      if (term_end) begin
        count_d      = '0;
        too_long_d   = 1'b0;
        has_letter_d = 1'b0;
        bank_d       = bank_q ^ emit;
      end else begin
        count_d      = cnt_upd;
        too_long_d   = tl_upd;
        has_letter_d = hl_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      too_long_q   <= 1'b0;
      has_letter_q <= 1'b0;
      bank_q       <= 1'b0;
    end else begin
      count_q      <= count_d;
      too_long_q   <= too_long_d;
      has_letter_q <= has_letter_d;
      bank_q       <= bank_d;
    end
  end

endmodule

### rtl/atok_desc_q.sv
// two-entry queue of finished term lengths between front and back end
module atok_desc_q (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  atok_pkg::desc_push_t desc_push_i,
  input  logic                 desc_pop_i,
  output atok_pkg::desc_stat_t desc_stat_o
);

  logic [atok_pkg::CntW-1:0]     len_q [atok_pkg::DescDepth];
  logic [atok_pkg::DescAw-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [atok_pkg::DescCntW-1:0] cnt_q, cnt_d;
  logic                          do_push, do_pop;

  always_comb begin
    do_push = desc_push_i.valid && (cnt_q != atok_pkg::DescCntW'(atok_pkg::DescDepth));
    do_pop  = desc_pop_i && (cnt_q != '0);
    wptr_d  = do_push ? wptr_q + atok_pkg::DescAw'(1) : wptr_q;
    rptr_d  = do_pop ? rptr_q + atok_pkg::DescAw'(1) : rptr_q;
    cnt_d   = cnt_q + atok_pkg::DescCntW'(do_push) - atok_pkg::DescCntW'(do_pop);
    desc_stat_o.valid = (cnt_q != '0);
    desc_stat_o.full  = (cnt_q == atok_pkg::DescCntW'(atok_pkg::DescDepth));
    desc_stat_o.len   = len_q[rptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      len_q[wptr_q] <= desc_push_i.len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

### rtl/atok_back.sv
// back end: double-banked term buffer, character read-out and result queue
module atok_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  atok_pkg::buf_wr_t    buf_wr_i,
  input  atok_pkg::desc_stat_t desc_stat_i,
  output logic                 desc_pop_o,
  input  logic                 pop,
  output logic                 empty,
  output atok_pkg::out_item_t  out_data_o
);

  logic [atok_pkg::CharW-1:0]   mem_q [2*atok_pkg::BufDepth];
  logic [atok_pkg::BufAw-1:0]   pos_q, pos_d;
  logic                         bank_q, bank_d;
  logic                         rd_v_q, rd_v_d;
  logic [atok_pkg::CharW-1:0]   rd_char_q;
  logic [atok_pkg::BufAw-1:0]   rd_pos_q;
  logic [atok_pkg::CntW-1:0]    rd_len_q;
  logic                         rd_last_q;
  atok_pkg::out_item_t          out_q [atok_pkg::OutDepth];
  logic [atok_pkg::OutAw-1:0]   owptr_q, owptr_d, orptr_q, orptr_d;
  logic [atok_pkg::OutCntW-1:0] ocnt_q, ocnt_d;
  logic [atok_pkg::OutCntW:0]   occ;
  logic                         pop_fire, issue, last_pos;
  atok_pkg::out_item_t          rd_item;

  always_comb begin
    pop_fire   = pop && (ocnt_q != '0);
    occ        = {1'b0, ocnt_q} + (atok_pkg::OutCntW + 1)'(rd_v_q);
    issue      = desc_stat_i.valid &&
                 (occ < (atok_pkg::OutCntW + 1)'(atok_pkg::OutDepth) +
                        (atok_pkg::OutCntW + 1)'(pop_fire));
    last_pos   = (atok_pkg::CntW'(pos_q) + atok_pkg::CntW'(1)) == desc_stat_i.len;
    desc_pop_o = issue && last_pos;
    pos_d      = pos_q;
    bank_d     = bank_q;
    if (issue) begin
      if (last_pos) begin
        pos_d  = '0;
        bank_d = !bank_q;
      end else begin
        pos_d  = pos_q + atok_pkg::BufAw'(1);
      end
    end
    rd_v_d = issue;

    rd_item.term_char     = rd_char_q;
    rd_item.char_position = 5'(rd_pos_q);
    rd_item.term_length   = 6'(rd_len_q);
    rd_item.last_char     = rd_last_q;

    owptr_d = rd_v_q ? owptr_q + atok_pkg::OutAw'(1) : owptr_q;
    orptr_d = pop_fire ? orptr_q + atok_pkg::OutAw'(1) : orptr_q;
    ocnt_d  = ocnt_q + atok_pkg::OutCntW'(rd_v_q) - atok_pkg::OutCntW'(pop_fire);

    empty      = (ocnt_q == '0);
    out_data_o = out_q[orptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (buf_wr_i.en) begin
      mem_q[buf_wr_i.addr] <= buf_wr_i.data;
    end
    if (issue) begin
      rd_char_q <= mem_q[{bank_q, pos_q}];
      rd_pos_q  <= pos_q;
      rd_len_q  <= desc_stat_i.len;
      rd_last_q <= last_pos;
    end
    if (rd_v_q) begin
      out_q[owptr_q] <= rd_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      bank_q  <= 1'b0;
      rd_v_q  <= 1'b0;
      owptr_q <= '0;
      orptr_q <= '0;
      ocnt_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      bank_q  <= bank_d;
      rd_v_q  <= rd_v_d;
      owptr_q <= owptr_d;
      orptr_q <= orptr_d;
      ocnt_q  <= ocnt_d;
    end
  end

  a_ocnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= atok_pkg::OutCntW'(atok_pkg::OutDepth))
    else $error("result queue over capacity");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> (ocnt_q != atok_pkg::OutCntW'(atok_pkg::OutDepth)) || pop_fire)
    else $error("read data arrives with result queue full");

  a_desc_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_stat_i.valid |-> (desc_stat_i.len != '0) &&
                          (desc_stat_i.len <= atok_pkg::CntW'(atok_pkg::LimitLen)))
    else $error("term length out of range");

  a_pos_in_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_stat_i.valid |-> atok_pkg::CntW'(pos_q) < desc_stat_i.len)
    else $error("read position past end of term");

endmodule

### rtl/alnum_term_tokenizer.sv
// top level of the alphanumeric term tokenizer
//
// input channel: one text byte per transaction with a flush mark, taken when
// push is high and full is low. letters and digits are gathered into a term,
// upper case folded to lower; any other byte or a set flush ends the term.
// result channel: one character per transaction, oldest shown while empty is
// low, taken when pop is high. each carries its position, the term length
// and a mark on the final character. terms that are too long or hold no
// letter are dropped with no result.
// throughput: one byte per cycle in while full is low, one character per
// cycle out while pop keeps up, the out side set by the single read port
// of the term buffer. a term's first character passes the length queue,
// read register and result queue after its terminating byte is taken.
// the term buffer has two banks, so two finished terms may wait; with both
// waiting, full stays high until the older term is read out. a stalled pop
// backs up into the buffer and then into full.
// reset clears all control state and empties both queues; no clearing pass.
module alnum_term_tokenizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  atok_pkg::in_item_t  in_data_i,
  output logic                empty,
  input  logic                pop,
  output atok_pkg::out_item_t out_data_o
);

  atok_pkg::buf_wr_t    buf_wr;
  atok_pkg::desc_push_t desc_push;
  atok_pkg::desc_stat_t desc_stat;
  logic                 desc_pop;

  assign full = desc_stat.full;

  atok_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_data_i   (in_data_i),
    .desc_stat_i (desc_stat),
    .buf_wr_o    (buf_wr),
    .desc_push_o (desc_push)
  );

  atok_desc_q u_desc_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_push_i (desc_push),
    .desc_pop_i  (desc_pop),
    .desc_stat_o (desc_stat)
  );

  atok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .buf_wr_i    (buf_wr),
    .desc_stat_i (desc_stat),
    .desc_pop_o  (desc_pop),
    .pop         (pop),
    .empty       (empty),
    .out_data_o  (out_data_o)
  );

endmodule
